FILE: hdl/vpad_pkg.sv
package vpad_pkg;

  localparam int unsigned COORD_WIDTH_DEF     = 16;
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 7;
  localparam int unsigned HALFCIRCLE          = 180;
  localparam int unsigned ACC_FRAC            = 16;
  localparam int unsigned STAGES              = 23;
  localparam int unsigned PRESHIFT_BASE       = 45;
  localparam int unsigned CORD_W              = 48;  // x/y datapath, signed
  localparam int unsigned ZACC_W              = 26;  // angle accumulator, signed
  localparam int unsigned OUT_W               = 16;  // result field width
  // prep + CORDIC stages + fold + round
  localparam int unsigned LANE_REGS           = STAGES + 3;

  // atan(2^-i) in degrees times 2^16, rounded to nearest
  function automatic logic [ZACC_W-1:0] atan_lut(input int unsigned idx);
    logic [ZACC_W-1:0] v;
    case (idx)
      0:       v = ZACC_W'(2949120);
      1:       v = ZACC_W'(1740967);
      2:       v = ZACC_W'(919879);
      3:       v = ZACC_W'(466945);
      4:       v = ZACC_W'(234379);
      5:       v = ZACC_W'(117304);
      6:       v = ZACC_W'(58666);
      7:       v = ZACC_W'(29335);
      8:       v = ZACC_W'(14668);
      9:       v = ZACC_W'(7334);
      10:      v = ZACC_W'(3667);
      11:      v = ZACC_W'(1833);
      12:      v = ZACC_W'(917);
      13:      v = ZACC_W'(458);
      14:      v = ZACC_W'(229);
      15:      v = ZACC_W'(115);
      16:      v = ZACC_W'(57);
      17:      v = ZACC_W'(29);
      18:      v = ZACC_W'(14);
      19:      v = ZACC_W'(7);
      20:      v = ZACC_W'(4);
      21:      v = ZACC_W'(2);
      22:      v = ZACC_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/vpad_lane.sv
// One vector: prep, unrolled CORDIC vectoring, quadrant fold, rounding.
module vpad_lane #(
  parameter int unsigned COORD_WIDTH     = vpad_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ANGLE_FRAC_BITS = vpad_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int unsigned ANG_W           = ANGLE_FRAC_BITS + 9
) (
  input  logic                                clk_i,
  input  logic [vpad_pkg::LANE_REGS-1:0]      en_i,
  input  logic signed [COORD_WIDTH-1:0]       x_i,
  input  logic signed [COORD_WIDTH-1:0]       y_i,
  output logic [ANG_W-1:0]                    angle_o
);

  localparam int unsigned NST    = vpad_pkg::STAGES;
  localparam int unsigned CW     = vpad_pkg::CORD_W;
  localparam int unsigned ZW     = vpad_pkg::ZACC_W;
  localparam int unsigned PRE    = vpad_pkg::PRESHIFT_BASE - COORD_WIDTH;
  localparam int unsigned RS     = vpad_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int unsigned HC     = vpad_pkg::HALFCIRCLE;
  localparam logic [ZW-1:0] QUARTER_Q = ZW'((HC / 2) << vpad_pkg::ACC_FRAC);
  localparam logic [ZW-1:0] HALF_Q    = ZW'(HC << vpad_pkg::ACC_FRAC);
  localparam logic [ZW-1:0] FULL_Q    = ZW'((2 * HC) << vpad_pkg::ACC_FRAC);
  localparam logic [ZW-1:0] RND_Q     = ZW'(1) << (RS - 1);
  localparam logic [ANG_W-1:0] A90    = ANG_W'((HC / 2) << ANGLE_FRAC_BITS);
  localparam logic [ANG_W-1:0] A180   = ANG_W'(HC << ANGLE_FRAC_BITS);
  localparam logic [ANG_W-1:0] A270   = ANG_W'((3 * HC / 2) << ANGLE_FRAC_BITS);
  localparam logic [ANG_W-1:0] A360   = ANG_W'((2 * HC) << ANGLE_FRAC_BITS);

  logic signed [CW-1:0] cx_q [NST+1];
  logic signed [CW-1:0] cy_q [NST+1];
  logic signed [ZW-1:0] z_q  [NST+1];
  logic                 xn_q [NST+1];
  logic                 yn_q [NST+1];
  logic                 sp_q [NST+2];
  logic [ANG_W-1:0]     spv_q[NST+2];
  logic [ZW-1:0]        f_q;
  logic [ANG_W-1:0]     ang_q;

  logic [COORD_WIDTH:0] ax_d, ay_d;
  logic                 xz_d, yz_d;
  logic [ANG_W-1:0]     spv_d;

  always_comb begin
    ax_d = x_i[COORD_WIDTH-1] ? (COORD_WIDTH+1)'(-$signed({x_i[COORD_WIDTH-1], x_i}))
                              : (COORD_WIDTH+1)'({1'b0, x_i});
    ay_d = y_i[COORD_WIDTH-1] ? (COORD_WIDTH+1)'(-$signed({y_i[COORD_WIDTH-1], y_i}))
                              : (COORD_WIDTH+1)'({1'b0, y_i});
    xz_d = (x_i == '0);
    yz_d = (y_i == '0);
    if (xz_d) begin
      if (y_i[COORD_WIDTH-1]) spv_d = A270;
      else if (!yz_d)         spv_d = A90;
      else                    spv_d = '0;
    end else begin
      spv_d = x_i[COORD_WIDTH-1] ? A180 : '0;
    end
  end

  // prep stage: fold to first quadrant, scale up, flag axis cases
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      cx_q[0]  <= $signed(CW'(ax_d) << PRE);
      cy_q[0]  <= $signed(CW'(ay_d) << PRE);
      z_q[0]   <= '0;
      xn_q[0]  <= x_i[COORD_WIDTH-1];
      yn_q[0]  <= y_i[COORD_WIDTH-1];
      sp_q[0]  <= xz_d | yz_d;
      spv_q[0] <= spv_d;
    end
  end

  // one micro-rotation per stage; >>> floors toward minus infinity
  for (genvar i = 0; i < NST; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i[i+1]) begin
        if (!cy_q[i][CW-1]) begin
          cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
          z_q[i+1]  <= z_q[i] + $signed(vpad_pkg::atan_lut(i));
        end else begin
          cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
          z_q[i+1]  <= z_q[i] - $signed(vpad_pkg::atan_lut(i));
        end
        xn_q[i+1]  <= xn_q[i];
        yn_q[i+1]  <= yn_q[i];
        sp_q[i+1]  <= sp_q[i];
        spv_q[i+1] <= spv_q[i];
      end
    end
  end

  logic [ZW-1:0] q_d, f_d;
  always_comb begin
    if (z_q[NST][ZW-1])                q_d = '0;
    else if ($unsigned(z_q[NST]) > QUARTER_Q) q_d = QUARTER_Q;
    else                               q_d = $unsigned(z_q[NST]);
    case ({xn_q[NST], yn_q[NST]})
      2'b00:   f_d = q_d;
      2'b10:   f_d = HALF_Q - q_d;
      2'b11:   f_d = HALF_Q + q_d;
      default: f_d = FULL_Q - q_d;
    endcase
  end

  // fold stage
  always_ff @(posedge clk_i) begin
    if (en_i[NST+1]) begin
      f_q          <= f_d;
      sp_q[NST+1]  <= sp_q[NST];
      spv_q[NST+1] <= spv_q[NST];
    end
  end

  logic [ZW-1:0]    rsum_d;
  logic [ANG_W-1:0] r_d;
  always_comb begin
    rsum_d = f_q + RND_Q;
    r_d    = ANG_W'(rsum_d >> RS);
    if (r_d >= A360) r_d = '0;
  end

  // round stage; axis cases bypass the rotation result
  always_ff @(posedge clk_i) begin
    if (en_i[NST+2]) begin
      ang_q <= sp_q[NST+1] ? spv_q[NST+1] : r_d;
    end
  end

  assign angle_o = ang_q;

endmodule

FILE: hdl/vpad_merge.sv
// Combine both lane angles: absolute gap, mask to field width, register.
module vpad_merge #(
  parameter int unsigned ANG_W = vpad_pkg::ANGLE_FRAC_BITS_DEF + 9
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ANG_W-1:0]            a1_i,
  input  logic [ANG_W-1:0]            a2_i,
  output logic [3*vpad_pkg::OUT_W-1:0] res_o
);

  localparam int unsigned OW = vpad_pkg::OUT_W;

  logic [ANG_W-1:0]  gap_d;
  logic [3*OW-1:0]   res_q;

  always_comb begin
    gap_d = (a1_i >= a2_i) ? (a1_i - a2_i) : (a2_i - a1_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= {OW'(gap_d), OW'(a2_i), OW'(a1_i)};
    end
  end

  assign res_o = res_q;

endmodule

FILE: hdl/vector_polar_angle_degrees_top.sv
// Polar angle of two vectors per item, in degrees with fixed-point fraction.
// Slave channel s_axis_*: one item holds two signed vectors (x, y).
// Master channel m_axis_*: one item holds both angles in [0, 360) and their
// absolute difference, each unsigned, degrees times 2^ANGLE_FRAC_BITS.
// Two identical lanes (one per vector) run a 23-stage unrolled CORDIC in
// vectoring mode on the first-quadrant magnitudes; a prep stage in front
// folds signs and flags the axis cases, a fold and a round stage follow,
// and a merge stage computes the gap and holds the output register.
// Throughput: one item per cycle while the receiver does not stall, set
// by the fully pipelined lanes.
// Each stage holds its own valid bit and advances whenever the next stage
// is empty or advancing, so bubbles collapse and input is taken while a
// result waits, until every stage is full. A stalled receiver holds the
// output item stable; upstream stages fill and then drop s_axis_tready.
// Reset clears all valid bits; the pipeline comes out empty.
module vector_polar_angle_degrees_top #(
  parameter int unsigned COORD_WIDTH     = vpad_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ANGLE_FRAC_BITS = vpad_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int unsigned IN_W            = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // first_x, first_y, second_x, second_y (COORD_WIDTH each), zero pad
  input  logic [IN_W-1:0]               s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // first_angle [15:0], second_angle [31:16], angle_gap [47:32]
  output logic [3*vpad_pkg::OUT_W-1:0]  m_axis_tdata
);

  localparam int unsigned NR    = vpad_pkg::LANE_REGS;
  localparam int unsigned ANG_W = ANGLE_FRAC_BITS + 9;
  localparam int unsigned CWD   = COORD_WIDTH;

  logic [NR-1:0] v_q;
  logic          ov_q;
  logic [NR:0]   rdy;
  logic [ANG_W-1:0] a1, a2;

  // ready chain from the output back to the input
  always_comb begin
    rdy[NR] = !ov_q || m_axis_tready;
    for (int i = NR - 1; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end

  assign s_axis_tready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      if (rdy[0]) v_q[0] <= s_axis_tvalid;
      for (int i = 1; i < NR; i++) begin
        if (rdy[i]) v_q[i] <= v_q[i-1];
      end
      if (rdy[NR]) ov_q <= v_q[NR-1];
    end
  end

  vpad_lane #(
    .COORD_WIDTH     (COORD_WIDTH),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .ANG_W           (ANG_W)
  ) u_lane_first (
    .clk_i   (clk_i),
    .en_i    (rdy[NR-1:0]),
    .x_i     ($signed(s_axis_tdata[0 +: CWD])),
    .y_i     ($signed(s_axis_tdata[CWD +: CWD])),
    .angle_o (a1)
  );

  vpad_lane #(
    .COORD_WIDTH     (COORD_WIDTH),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .ANG_W           (ANG_W)
  ) u_lane_second (
    .clk_i   (clk_i),
    .en_i    (rdy[NR-1:0]),
    .x_i     ($signed(s_axis_tdata[2*CWD +: CWD])),
    .y_i     ($signed(s_axis_tdata[3*CWD +: CWD])),
    .angle_o (a2)
  );

  vpad_merge #(
    .ANG_W (ANG_W)
  ) u_merge (
    .clk_i (clk_i),
    .en_i  (rdy[NR]),
    .a1_i  (a1),
    .a2_i  (a2),
    .res_o (m_axis_tdata)
  );

  assign m_axis_tvalid = ov_q;

endmodule

FILE: hdl/vpad_checker.sv
module vpad_checker #(
  parameter int unsigned ANGLE_FRAC_BITS = vpad_pkg::ANGLE_FRAC_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [3*vpad_pkg::OUT_W-1:0]  m_axis_tdata
);

  localparam int unsigned FULL = (2 * vpad_pkg::HALFCIRCLE) << ANGLE_FRAC_BITS;
  localparam logic [15:0] FULL16 = 16'(FULL);
  localparam bit NARROW = (ANGLE_FRAC_BITS <= 7);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && NARROW |->
      (m_axis_tdata[15:0] < FULL16) && (m_axis_tdata[31:16] < FULL16))
    else $error("angle outside full circle");

  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && NARROW && (m_axis_tdata[15:0] == m_axis_tdata[31:16]) |->
      m_axis_tdata[47:32] == 16'd0)
    else $error("gap nonzero for equal angles");

  a_gap_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && NARROW |->
      (m_axis_tdata[47:32] <= m_axis_tdata[15:0]) ||
      (m_axis_tdata[47:32] <= m_axis_tdata[31:16]))
    else $error("gap larger than both angles");

endmodule

bind vector_polar_angle_degrees_top vpad_checker #(
  .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_vpad_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: sim/tb_vector_polar_angle_degrees_top.sv
module tb_vector_polar_angle_degrees_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW   = vpad_pkg::COORD_WIDTH_DEF;
  localparam int unsigned FRAC = vpad_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int unsigned OW   = vpad_pkg::OUT_W;
  localparam int unsigned NSTG = vpad_pkg::STAGES;
  localparam int unsigned IN_W = ((4 * CW + 7) / 8) * 8;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = vpad_pkg::LANE_REGS + 10;
  localparam int unsigned RANDOM_ITEMS   = 1250;

  typedef struct packed {
    logic [OW-1:0] gap;
    logic [OW-1:0] second;
    logic [OW-1:0] first;
  } angles_t;

  // Table of atan(2^-i), degrees times 2^16, kept locally for the predictor
  localparam longint ATAN_Q16 [NSTG] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1
  };

  // Predict the polar angle of one vector, degrees times 2^FRAC, in [0, 360)
  function automatic longint unsigned angle_of(logic signed [CW-1:0] xs,
                                               logic signed [CW-1:0] ys);
    longint x, y, cx, cy, z, q, f, dx, dy, r, full, quarter, half;
    int unsigned rs;
    x = xs;
    y = ys;
    quarter = longint'(vpad_pkg::HALFCIRCLE / 2) << vpad_pkg::ACC_FRAC;
    half    = longint'(vpad_pkg::HALFCIRCLE) << vpad_pkg::ACC_FRAC;
    if (x == 0) begin
      if (y < 0) return longint'(3 * vpad_pkg::HALFCIRCLE / 2) << FRAC;
      if (y > 0) return longint'(vpad_pkg::HALFCIRCLE / 2) << FRAC;
      return 0;
    end
    if (y == 0) return (x < 0) ? (longint'(vpad_pkg::HALFCIRCLE) << FRAC) : 0;
    cx = (x < 0 ? -x : x) << (vpad_pkg::PRESHIFT_BASE - CW);
    cy = (y < 0 ? -y : y) << (vpad_pkg::PRESHIFT_BASE - CW);
    z = 0;
    for (int i = 0; i < NSTG; i++) begin
      dx = cy >>> i;  // arithmetic shift floors toward minus infinity
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += ATAN_Q16[i];
      end else begin
        cx -= dx; cy += dy; z -= ATAN_Q16[i];
      end
    end
    q = (z < 0) ? 0 : ((z > quarter) ? quarter : z);
    if (x > 0 && y > 0)      f = q;
    else if (x < 0 && y > 0) f = half - q;
    else if (x < 0)          f = half + q;
    else                     f = 2 * half - q;
    rs   = vpad_pkg::ACC_FRAC - FRAC;
    full = longint'(2 * vpad_pkg::HALFCIRCLE) << FRAC;
    r    = (f + (longint'(1) << (rs - 1))) >>> rs;
    // rounding up to a full circle wraps to zero
    if (r >= full) r = 0;
    return r;
  endfunction

  class angle_scoreboard;
    angles_t pending[$];
    int unsigned errors;

    function void note_vectors(logic [IN_W-1:0] data);
      longint unsigned a1, a2;
      angles_t e;
      a1 = angle_of(data[0 +: CW], data[CW +: CW]);
      a2 = angle_of(data[2*CW +: CW], data[3*CW +: CW]);
      e.first  = a1[OW-1:0];
      e.second = a2[OW-1:0];
      e.gap    = (a1 >= a2) ? OW'(a1 - a2) : OW'(a2 - a1);
      pending.push_back(e);
    endfunction

    function void check_angles(angles_t got);
      angles_t e;
      if (pending.size() == 0) begin
        $error("unexpected result item %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.first !== e.first) begin
        $error("first_angle: expected %0d, actual %0d", e.first, got.first);
        errors++;
      end
      if (got.second !== e.second) begin
        $error("second_angle: expected %0d, actual %0d", e.second, got.second);
        errors++;
      end
      if (got.gap !== e.gap) begin
        $error("angle_gap: expected %0d, actual %0d", e.gap, got.gap);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [3*OW-1:0]  m_axis_tdata;

  angle_scoreboard board = new();
  int unsigned idle_pct = 35;   // idling share in percent, zero in the calm stretch
  int unsigned quiet_cycles = 0;

  vector_polar_angle_degrees_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: check on accepted items, stall at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_angles(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog: count cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Send one item of two vectors, with random gaps before it
  task automatic send_vectors(logic [CW-1:0] fx, logic [CW-1:0] fy,
                              logic [CW-1:0] sx, logic [CW-1:0] sy);
    logic [IN_W-1:0] data;
    data = '0;
    data[0 +: CW] = fx;
    data[CW +: CW] = fy;
    data[2*CW +: CW] = sx;
    data[3*CW +: CW] = sy;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_vectors(data);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  // Pick a coordinate: mostly uniform, sometimes an edge value
  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(9))
      0: return '0;
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return {1'b0, {(CW-1){1'b1}}};
      3: return CW'($urandom_range(7)) - CW'(3);
      default: return CW'($urandom);
    endcase
  endfunction

  localparam logic [CW-1:0] MAXP = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MAXN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] MONE = '1;

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero vector, the four axes, extremes, quadrants, near-360 rounding
    send_vectors('0, '0, '0, '0);
    send_vectors(ONE, '0, MAXN, '0);
    send_vectors('0, MAXP, '0, MAXN);
    send_vectors(MAXP, '0, '0, ONE);
    send_vectors(MAXP, MAXP, MAXN, MAXN);
    send_vectors(MAXN, MAXP, MAXP, MAXN);
    send_vectors(MAXP, MONE, ONE, MONE);
    send_vectors(MAXN, MONE, MAXN, ONE);
    send_vectors(ONE, MAXP, MONE, MAXN);
    send_vectors(MAXP, ONE, MAXN, MONE);
    send_vectors(MAXN, MAXN, MAXP, MAXP);
    send_vectors(ONE, ONE, MONE, ONE);
    send_vectors(MONE, MONE, ONE, MONE);
    send_vectors(CW'(16'h5555), CW'(16'haaaa), CW'(16'haaaa), CW'(16'h5555));

    // Hold the sender until all results are back
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // calm stretch with no idling on either side
      idle_pct = (n >= 400 && n < 650) ? 0 : 35;
      send_vectors(pick_coord(), pick_coord(), pick_coord(), pick_coord());
      if (n == 800) wait_drained();
    end
    idle_pct = 35;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.errors == 0 && board.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
